FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of the rotor cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SRLC_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define SRLC_ASSERT_NR(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("%m: assertion failed");

`endif

FILE: hdl/srlc_pkg.sv
// Package of the rotor cipher: sizes, register indexes, sequencer states and helpers.
`default_nettype none

package srlc_pkg;

    localparam int ROTORS     = 52;
    localparam int IDX_W      = $clog2(ROTORS);
    localparam int POS_W      = 5;
    localparam int LETTERS    = 26;
    localparam int KEY_W      = POS_W * ROTORS;
    localparam int KEY_OFF_W  = $clog2(KEY_W);
    localparam int ALU_W      = IDX_W;

    localparam logic [6:0] ASCII_A  = 7'd65;
    localparam logic [6:0] MOD_POS  = 7'(LETTERS);
    localparam logic [6:0] MOD_WIRE = 7'(ROTORS);

    typedef enum logic [2:0] {
        REG_KEY_A     = 3'd0,
        REG_KEY_B     = 3'd1,
        REG_KEY_C     = 3'd2,
        REG_KEY_D     = 3'd3,
        REG_KEY_E     = 3'd4,
        REG_DIRECTION = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ_P,
        ST_READ_FB,
        ST_POS,
        ST_BWD,
        ST_SUM,
        ST_OUT
    } state_t;

    // Operation of the shared modular adder.
    typedef struct packed {
        logic sub;   // subtract instead of add
        logic wide;  // modulus is the rotor count instead of the alphabet size
    } alu_op_t;

    // Letter value of a raw byte: (byte - 65) mod 26, by conditional subtraction.
    function automatic logic [POS_W-1:0] letter_value(input logic [7:0] raw);
        logic [8:0] v;
        begin
            v = {1'b0, raw} + 9'd195;
            if (v >= 9'd416) v = v - 9'd416;
            if (v >= 9'd208) v = v - 9'd208;
            if (v >= 9'd104) v = v - 9'd104;
            if (v >= 9'd52)  v = v - 9'd52;
            if (v >= 9'd26)  v = v - 9'd26;
            letter_value = v[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/srlc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module srlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/srlc_alu.sv
// Shared modular add and subtract unit, modulus 26 or 52.
`default_nettype none

module srlc_alu (
    input  srlc_pkg::alu_op_t          op,
    input  logic [srlc_pkg::ALU_W-1:0] a,
    input  logic [srlc_pkg::ALU_W-1:0] b,
    output logic [srlc_pkg::ALU_W-1:0] y
);

    import srlc_pkg::*;

    logic [ALU_W:0] modulus;
    logic [ALU_W:0] sum;
    logic [ALU_W:0] diff;
    logic [ALU_W:0] wrapped;

    // Both operands are below the modulus, so one correction step suffices.
    always_comb
    begin
        modulus = op.wide ? MOD_WIRE : MOD_POS;
        sum     = {1'b0, a} + {1'b0, b};
        diff    = {1'b0, a} - {1'b0, b};
        if (op.sub)
        begin
            wrapped = diff[ALU_W] ? (diff + modulus) : diff;
        end
        else
        begin
            wrapped = (sum >= modulus) ? (sum - modulus) : sum;
        end
        y = wrapped[ALU_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hdl/stepping_rotor_letter_cipher_core.sv
// Top level of the 52-rotor stepping letter cipher with its step sequencer.
//
// Usage. Input transactions on in_valid/in_ready carry letter_in (a raw byte)
// and restart. Each input transaction yields exactly one output transaction
// on out_valid/out_ready carrying letter_out, an ASCII capital letter.
// Configuration transactions on cfg_valid/cfg_ready write the key registers
// (indexes 0 to 4) and the direction bit (index 5); other indexes are ignored.
// The rotor state lives in three 52-entry RAMs that one modular adder updates
// step by step, so in_ready is high only while the sequencer is idle.
// A plain item passes through the states READ_FB, POS, BWD, SUM and OUT and
// returns to IDLE, where the next item can be accepted; OUT loads its result
// into the output register once that register is free. An item with restart
// set first reloads every rotor from the key in ST_SWEEP, one rotor per cycle,
// and then passes ST_READ_P. After reset the block runs an initialization pass
// over the RAMs with in_ready low; configuration writes are taken at all times.
// A finished result sits in an output register, so the next item is accepted
// while it waits; a stalled receiver only holds up the item after that one.
`default_nettype none

module stepping_rotor_letter_cipher_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  letter_in,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [6:0]                  letter_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [59:0]                 cfg_data
);

    import srlc_pkg::*;

    // Control state.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] sweep_reg;
    logic             restart_reg;
    logic             out_valid_reg;

    // Configuration registers.
    logic [59:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [19:0] key_e_reg;
    logic        direction_reg;

    // Working registers of one step.
    logic [POS_W-1:0] sum_reg;
    logic [POS_W-1:0] letter_reg;
    logic [POS_W-1:0] pos_p_reg;
    logic [IDX_W-1:0] b_reg;
    logic [POS_W-1:0] gain_reg;
    logic [IDX_W-1:0] bwdb_reg;
    logic [6:0]       letter_out_reg;

    // RAM ports.
    logic             pos_we, fwd_we, bwd_we;
    logic [IDX_W-1:0] waddr;
    logic [POS_W-1:0] pos_wdata, pos_rdata;
    logic [IDX_W-1:0] fwd_wdata, fwd_rdata;
    logic [IDX_W-1:0] bwd_wdata, bwd_rdata;
    logic [IDX_W-1:0] pos_raddr, bwd_raddr;

    // Shared adder.
    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_y;

    // Key letter of the rotor being loaded, reduced into the alphabet.
    logic [KEY_W-1:0]     key_vec;
    logic [KEY_OFF_W-1:0] key_off;
    logic [POS_W-1:0]     key_raw;
    logic [POS_W-1:0]     key_pos;

    logic in_fire;
    logic out_load;
    logic sweep_last;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign letter_out = letter_out_reg;
    assign cfg_ready  = 1'b1;

    assign key_vec    = {key_e_reg, key_d_reg, key_c_reg, key_b_reg, key_a_reg};
    assign key_off    = KEY_OFF_W'({3'b000, sweep_reg} * 9'd5);
    assign key_raw    = key_vec[key_off +: POS_W];
    assign key_pos    = (key_raw >= POS_W'(LETTERS)) ? (key_raw - POS_W'(LETTERS)) : key_raw;
    assign sweep_last = (sweep_reg == IDX_W'(ROTORS - 1));

    srlc_ram #(.WIDTH(POS_W), .DEPTH(ROTORS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    srlc_ram #(.WIDTH(IDX_W), .DEPTH(ROTORS)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (waddr),
        .wdata (fwd_wdata),
        .raddr (ptr_reg),
        .rdata (fwd_rdata)
    );

    srlc_ram #(.WIDTH(IDX_W), .DEPTH(ROTORS)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (waddr),
        .wdata (bwd_wdata),
        .raddr (bwd_raddr),
        .rdata (bwd_rdata)
    );

    srlc_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Sequencer: next state, RAM controls and the operands of the shared adder.
    always_comb
    begin
        state_next = state_reg;
        pos_we     = 1'b0;
        fwd_we     = 1'b0;
        bwd_we     = 1'b0;
        waddr      = ptr_reg;
        pos_wdata  = alu_y[POS_W-1:0];
        fwd_wdata  = alu_y;
        bwd_wdata  = alu_y;
        pos_raddr  = ptr_reg;
        bwd_raddr  = ptr_reg;
        alu_op     = '{sub: 1'b0, wide: 1'b0};
        alu_a      = '0;
        alu_b      = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // Rewrite one rotor with its key position (zero in the pass after reset) and
                // identity wiring, and fold the new position into the running sum.
                pos_we    = 1'b1;
                fwd_we    = 1'b1;
                bwd_we    = 1'b1;
                waddr     = sweep_reg;
                pos_wdata = restart_reg ? key_pos : '0;
                fwd_wdata = sweep_last ? '0 : (sweep_reg + 1'b1);
                bwd_wdata = (sweep_reg == '0) ? IDX_W'(ROTORS - 1) : (sweep_reg - 1'b1);
                alu_a     = ALU_W'(sum_reg);
                alu_b     = ALU_W'(pos_wdata);
                if (sweep_last)
                begin
                    state_next = restart_reg ? ST_READ_P : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = restart ? ST_SWEEP : ST_READ_FB;
                end
            end
            ST_READ_P:
            begin
                state_next = ST_READ_FB;
            end
            ST_READ_FB:
            begin
                // Entries of the stepped rotor are on the read ports: fetch the
                // position of its forward contact and the backward contact of
                // its backward contact, and double the forward contact.
                pos_raddr  = fwd_rdata;
                bwd_raddr  = bwd_rdata;
                fwd_we     = 1'b1;
                alu_op     = '{sub: 1'b0, wide: 1'b1};
                alu_a      = fwd_rdata;
                alu_b      = fwd_rdata;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                pos_we     = 1'b1;
                alu_a      = ALU_W'(pos_p_reg);
                alu_b      = ALU_W'(pos_rdata);
                state_next = ST_BWD;
            end
            ST_BWD:
            begin
                bwd_we     = 1'b1;
                alu_op     = '{sub: 1'b0, wide: 1'b1};
                alu_a      = b_reg;
                alu_b      = bwdb_reg;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                alu_a      = ALU_W'(sum_reg);
                alu_b      = ALU_W'(gain_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Shift the letter by the position sum; wait while the output
                // register still holds a result nobody has taken.
                alu_op = '{sub: direction_reg, wide: 1'b0};
                alu_a  = ALU_W'(letter_reg);
                alu_b  = ALU_W'(sum_reg);
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            ptr_reg       <= '0;
            sweep_reg     <= '0;
            restart_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_SWEEP:
                begin
                    sum_reg   <= alu_y[POS_W-1:0];
                    sweep_reg <= sweep_last ? '0 : (sweep_reg + 1'b1);
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        restart_reg <= restart;
                        if (restart)
                        begin
                            sum_reg   <= '0;
                            sweep_reg <= '0;
                            ptr_reg   <= '0;
                        end
                    end
                end
                ST_SUM:
                begin
                    sum_reg <= alu_y[POS_W-1:0];
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        ptr_reg <= (ptr_reg == IDX_W'(ROTORS - 1)) ? '0 : (ptr_reg + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration registers, written whenever a configuration transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            key_c_reg     <= '0;
            key_d_reg     <= '0;
            key_e_reg     <= '0;
            direction_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_A:     key_a_reg     <= cfg_data;
                REG_KEY_B:     key_b_reg     <= cfg_data;
                REG_KEY_C:     key_c_reg     <= cfg_data;
                REG_KEY_D:     key_d_reg     <= cfg_data;
                REG_KEY_E:     key_e_reg     <= cfg_data[19:0];
                REG_DIRECTION: direction_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            letter_reg <= letter_value(letter_in);
        end
        if (state_reg == ST_READ_FB)
        begin
            pos_p_reg <= pos_rdata;
            b_reg     <= bwd_rdata;
        end
        if (state_reg == ST_POS)
        begin
            gain_reg <= pos_rdata;
            bwdb_reg <= bwd_rdata;
        end
        if (out_load)
        begin
            letter_out_reg <= {2'b00, alu_y[POS_W-1:0]} + ASCII_A;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/srlc_checker.sv
// Port-level checker of the rotor cipher and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module srlc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] letter_out
);

    // The block works on one item at a time, so it drops ready after each transaction.
    `SRLC_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

    // A result that is not taken stays on the port unchanged.
    `SRLC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(letter_out)))

    // Every result is a capital letter.
    `SRLC_ASSERT(a_out_letter, clk, rst_n, out_valid |-> (letter_out >= 7'd65 && letter_out <= 7'd90))

    // No input is taken while reset holds the block in its initialization pass.
    `SRLC_ASSERT_NR(a_reset_not_ready, clk, !rst_n |-> !in_ready)

endmodule

bind stepping_rotor_letter_cipher_core srlc_checker u_srlc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .letter_out (letter_out)
);

`default_nettype wire

FILE: sim/cipher_checker.sv
// Checker of the rotor cipher: tracks the cipher state and compares every output transaction.
module cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  letter_in,
    input  logic        restart,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  letter_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data,
    output int          fail_count,
    output int          letters_due
);

    import srlc_pkg::*;

    localparam int KEY_WORDS    = 5;
    localparam int KEYS_PER_REG = 12;

    logic [59:0]      key_word [KEY_WORDS];
    logic             decrypt;
    logic [POS_W-1:0] rotor_pos [ROTORS];
    logic [5:0]       fwd_link [ROTORS];
    logic [5:0]       bwd_link [ROTORS];
    int               step_ptr;
    int               pos_total;
    logic [6:0]       expected_letters [$];
    logic [6:0]       want;
    logic [6:0]       fresh;

    task automatic rewire();
        for (int i = 0; i < ROTORS; i++)
        begin
            fwd_link[i] = 6'((i + 1) % ROTORS);
            bwd_link[i] = 6'((i + ROTORS - 1) % ROTORS);
        end
        step_ptr = 0;
    endtask

    task automatic clear_cipher();
        for (int i = 0; i < KEY_WORDS; i++)
            key_word[i] = '0;
        decrypt = 1'b0;
        for (int i = 0; i < ROTORS; i++)
            rotor_pos[i] = '0;
        pos_total = 0;
        rewire();
    endtask

    // Restart: the wiring goes back to identity and every rotor takes its key letter.
    task automatic load_key();
        logic [4:0] key_letter;
        rewire();
        pos_total = 0;
        for (int i = 0; i < ROTORS; i++)
        begin
            key_letter = key_word[i / KEYS_PER_REG][5 * (i % KEYS_PER_REG) +: 5];
            rotor_pos[i] = POS_W'(key_letter % LETTERS);
            pos_total = (pos_total + int'(rotor_pos[i])) % LETTERS;
        end
    endtask

    // One letter: optional reload, one rotor step, then a shift by the position total.
    task automatic cipher_letter(input logic [7:0] raw, input logic reload,
                                 output logic [6:0] letter);
        int p;
        int f;
        int b;
        int gain;
        int back_gain;
        int value;
        if (reload)
            load_key();
        p         = step_ptr;
        f         = int'(fwd_link[p]) % ROTORS;
        b         = int'(bwd_link[p]) % ROTORS;
        gain      = int'(rotor_pos[f]) % LETTERS;
        back_gain = int'(bwd_link[b]) % ROTORS;
        rotor_pos[p] = POS_W'((int'(rotor_pos[p]) + gain) % LETTERS);
        pos_total    = (pos_total + gain) % LETTERS;
        fwd_link[p]  = 6'((2 * int'(fwd_link[p])) % ROTORS);
        bwd_link[p]  = 6'((int'(bwd_link[p]) + back_gain) % ROTORS);
        step_ptr     = (p + 1) % ROTORS;

        value = (int'(raw) - int'(ASCII_A) + LETTERS * LETTERS) % LETTERS;
        if (decrypt)
            value = (value + LETTERS - pos_total) % LETTERS;
        else
            value = (value + pos_total) % LETTERS;
        letter = 7'(value + int'(ASCII_A));
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [59:0] data);
        case (reg_index_t'(idx))
            REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D: key_word[idx] = data;
            REG_KEY_E:     key_word[REG_KEY_E] = {40'd0, data[19:0]};
            REG_DIRECTION: decrypt = data[0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [6:0] got,
                                   input logic [6:0] wanted);
        $display("mismatch at %0t: %s, letter_out %0d, expected %0d",
                 $realtime, what, got, wanted);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cipher();
            expected_letters.delete();
            fail_count = 0;
            letters_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            // Retire the oldest result before queueing a new one from this edge.
            if (out_valid && out_ready)
            begin
                if (expected_letters.size() == 0)
                    report_mismatch("result with none pending", letter_out, '0);
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter_out !== want)
                        report_mismatch("wrong letter", letter_out, want);
                end
            end
            if (in_valid && in_ready)
            begin
                cipher_letter(letter_in, restart, fresh);
                expected_letters.push_back(fresh);
            end
            letters_due <= expected_letters.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top of the rotor cipher: clock, reset, stimulus, watchdog and verdict.
module tb;
    import srlc_pkg::*;

    // Indexes past the last register; writes to them must leave everything alone.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Longest correct quiet spell is a restart item or the initialization pass
    // after reset; this bound is many times longer than either.
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int IDLE_PERCENT = 9;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  letter_in;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  letter_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;

    int          fail_count;
    int          letters_due;
    int          quiet_cycles;
    logic        calm;

    stepping_rotor_letter_cipher_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .letter_in  (letter_in),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .letter_out (letter_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cipher_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .letter_in   (letter_in),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .letter_out  (letter_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .letters_due (letters_due)
    );

    // Clock with a period of 8 time units.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver drops out_ready at random with a chance of 9 percent. While calm
    // is set it stays ready, which gives a long stretch with no stalls at all.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // The watchdog ends the run with a failure once quiet_cycles, which reset and
    // every transaction of any kind clear, reaches QUIET_LIMIT.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One configuration transaction. Valid is lowered and the task waits on a clock
    // edge, so a following write never assigns cfg_valid twice in one time step.
    task automatic write_reg(input logic [2:0] idx, input logic [59:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One input transaction. The task returns at the edge where the letter was
    // taken, with in_valid still high, so the next letter may follow at once.
    task automatic send_letter(input logic [7:0] raw, input logic reload);
        in_valid  <= 1'b1;
        letter_in <= raw;
        restart   <= reload;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic rest_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted letter has come back, then
    // let the sequencer settle before any register write.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (letters_due != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Key words: fully random bits (letters 26 to 31 among them), all letters
    // valid, all zero or all ones.
    function automatic logic [59:0] pick_key_word();
        logic [59:0] word;
        case ($urandom_range(0, 9))
            0:       word = '0;
            1:       word = '1;
            2, 3, 4:
            begin
                for (int j = 0; j < 12; j++)
                    word[5 * j +: 5] = 5'($urandom_range(0, LETTERS - 1));
            end
            default: word = 60'({$urandom, $urandom});
        endcase
        return word;
    endfunction

    // Mostly capitals, with lower case and arbitrary bytes mixed in.
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 8'($urandom_range(int'(ASCII_A), int'(ASCII_A) + LETTERS - 1));
        else if (roll < 80)
            return 8'($urandom_range(97, 122));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // A fresh random configuration: every register, sometimes a spare index too.
    task automatic configure_random();
        write_reg(REG_KEY_A, pick_key_word());
        write_reg(REG_KEY_B, pick_key_word());
        write_reg(REG_KEY_C, pick_key_word());
        write_reg(REG_KEY_D, pick_key_word());
        write_reg(REG_KEY_E, 60'({$urandom, $urandom}));
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      60'({$urandom, $urandom}));
        write_reg(REG_DIRECTION, 60'({$urandom, $urandom}));
    endtask

    // One random phase. It normally opens with a restart so the key is in
    // play; now and then it runs on from whatever state the rotors were left in.
    task automatic pump_letters(input int count, input logic hold_midway);
        logic reload;
        for (int k = 0; k < count; k++)
        begin
            if (hold_midway && k == count / 2)
                wait_drained();
            if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
                rest_sender($urandom_range(1, 8));
            if (k == 0)
                reload = ($urandom_range(0, 9) != 0);
            else
                reload = ($urandom_range(0, 39) == 0);
            send_letter(pick_byte(), reload);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        letter_in <= '0;
        restart   <= 1'b0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        calm      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // With no restart ever given the cipher runs from the reset state, where
        // every position is zero; bytes at and outside the capital range.
        send_letter(8'd0, 1'b0);
        send_letter(8'd255, 1'b0);
        send_letter(8'd65, 1'b0);
        send_letter(8'd90, 1'b0);
        send_letter(8'd64, 1'b0);
        send_letter(8'd91, 1'b0);
        send_letter(8'd97, 1'b0);
        send_letter(8'd122, 1'b0);
        wait_drained();

        // All-ones key: every key letter is 31, above the alphabet, and must be
        // reduced on restart. Data wider than a register is masked. Spare indexes
        // are written and must change nothing. Direction goes to decrypt.
        write_reg(REG_KEY_A, '1);
        write_reg(REG_KEY_B, '1);
        write_reg(REG_KEY_C, '1);
        write_reg(REG_KEY_D, '1);
        write_reg(REG_KEY_E, '1);
        write_reg(REG_DIRECTION, '1);
        write_reg(REG_SPARE_LO, '0);
        write_reg(REG_SPARE_HI, '1);
        send_letter(8'd65, 1'b1);
        send_letter(8'd0, 1'b0);
        send_letter(8'd255, 1'b0);
        send_letter(8'd90, 1'b0);
        send_letter(8'd91, 1'b0);
        send_letter(8'd64, 1'b1);
        send_letter(8'd122, 1'b0);
        wait_drained();

        // Highest valid letter everywhere, encrypt. The upper bits of the last
        // key word and of the direction word are set to check masking again.
        write_reg(REG_KEY_A, {12{5'd25}});
        write_reg(REG_KEY_B, {12{5'd25}});
        write_reg(REG_KEY_C, {12{5'd25}});
        write_reg(REG_KEY_D, {12{5'd25}});
        write_reg(REG_KEY_E, {{40{1'b1}}, {4{5'd25}}});
        write_reg(REG_DIRECTION, {{59{1'b1}}, 1'b0});
        send_letter(8'd90, 1'b1);
        send_letter(8'd65, 1'b0);
        send_letter(8'd128, 1'b0);
        send_letter(8'd77, 1'b0);
        send_letter(8'd1, 1'b1);
        wait_drained();

        // Random phases, each with a new configuration. Phase 3 runs without any
        // idling on either side; phase 2 holds the sender midway until every
        // pending letter has come back.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            calm <= (phase == 3);
            configure_random();
            pump_letters(PHASE_ITEMS,
                         phase == 2 || (phase != 3 && $urandom_range(0, 3) == 0));
        end

        wait_drained();
        calm <= 1'b0;
        repeat (20) @(posedge clk);

        if (fail_count == 0 && letters_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
